// File: src/kwl_pkg.sv
package kwl_pkg;

  localparam int LINE_BITS_DEF = 16;
  localparam int LINE_OUT_W    = 16;
  localparam int QUEUE_DEPTH   = 4;
  localparam int QPTR_W        = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    OP_CHAR = 2'd0,
    OP_EOL  = 2'd1,
    OP_EOS  = 2'd2,
    OP_NONE = 2'd3
  } opcode_t;

  typedef enum logic [3:0] {
    CLS_SPACE,
    CLS_LPAREN,
    CLS_RPAREN,
    CLS_PLUS,
    CLS_MINUS,
    CLS_STAR,
    CLS_PERCENT,
    CLS_COMMA,
    CLS_SLASH,
    CLS_QUOTE,
    CLS_DIGIT,
    CLS_ALPHA,
    CLS_BAD
  } char_cls_t;

  typedef enum logic [4:0] {
    TK_EOF        = 5'd0,
    TK_DEFINE     = 5'd1,
    TK_CALL       = 5'd2,
    TK_IDENT      = 5'd3,
    TK_STRING     = 5'd4,
    TK_LPAREN     = 5'd5,
    TK_RPAREN     = 5'd6,
    TK_NUMBER     = 5'd7,
    TK_START      = 5'd8,
    TK_END        = 5'd9,
    TK_PLUS       = 5'd10,
    TK_MINUS      = 5'd11,
    TK_STAR       = 5'd12,
    TK_SLASH      = 5'd13,
    TK_SLASHSLASH = 5'd14,
    TK_PERCENT    = 5'd15,
    TK_COMMA      = 5'd16,
    TK_TEXTBYTE   = 5'd17,
    TK_BADCHAR    = 5'd18,
    TK_UNTERM     = 5'd19
  } token_kind_t;

  typedef enum logic [2:0] {
    M_IDLE   = 3'd0,
    M_IDENT  = 3'd1,
    M_NUMBER = 3'd2,
    M_STRING = 3'd3,
    M_SLASH  = 3'd4,
    M_HALT   = 3'd5
  } lex_mode_t;

  typedef struct packed {
    opcode_t    opcode;
    logic [7:0] char_code;
    char_cls_t  cls;
  } lex_item_t;

  // keyword prefixes, first character in the low byte
  localparam logic [39:0] KW_DEFIN = "nifed";
  localparam logic [39:0] KW_CALL  = {8'h00, "llac"};
  localparam logic [39:0] KW_START = "trats";
  localparam logic [39:0] KW_END   = {16'h0000, "dne"};

  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_E     = 8'h65;

endpackage

// File: src/kwl_if.sv
interface kwl_char_if;
  logic       valid;
  logic       ready;
  logic [1:0] opcode;
  logic [7:0] char_code;

  modport source (output valid, output opcode, output char_code, input ready);
  modport sink   (input valid, input opcode, input char_code, output ready);
endinterface

interface kwl_tok_if;
  logic                          valid;
  logic                          ready;
  logic [4:0]                    token_kind;
  logic [7:0]                    text_byte;
  logic [kwl_pkg::LINE_OUT_W-1:0] line_number;
  logic                          last;

  modport source (output valid, output token_kind, output text_byte,
                  output line_number, output last, input ready);
  modport sink   (input valid, input token_kind, input text_byte,
                  input line_number, input last, output ready);
endinterface

// File: src/kwl_front.sv
module kwl_front (
  kwl_char_if.sink           chars,
  input  logic               full,
  output logic               push,
  output kwl_pkg::lex_item_t push_item
);
  import kwl_pkg::*;

  function automatic char_cls_t classify(logic [7:0] c);
    char_cls_t k;
    if (c == 8'd32 || (c >= 8'd9 && c <= 8'd13)) k = CLS_SPACE;
    else if (c == 8'h28) k = CLS_LPAREN;
    else if (c == 8'h29) k = CLS_RPAREN;
    else if (c == 8'h2B) k = CLS_PLUS;
    else if (c == 8'h2D) k = CLS_MINUS;
    else if (c == 8'h2A) k = CLS_STAR;
    else if (c == 8'h25) k = CLS_PERCENT;
    else if (c == 8'h2C) k = CLS_COMMA;
    else if (c == 8'h2F) k = CLS_SLASH;
    else if (c == CH_QUOTE) k = CLS_QUOTE;
    else if (c >= 8'h30 && c <= 8'h39) k = CLS_DIGIT;
    else if ((c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A) || c == 8'h5F)
      k = CLS_ALPHA;
    else k = CLS_BAD;
    return k;
  endfunction

  assign chars.ready = !full;
  assign push        = chars.valid && !full;

  always_comb begin
    push_item.opcode    = opcode_t'(chars.opcode);
    push_item.char_code = chars.char_code;
    push_item.cls       = classify(chars.char_code);
  end

endmodule

// File: src/kwl_queue.sv
module kwl_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  kwl_pkg::lex_item_t push_item,
  output logic               full,
  output logic               head_valid,
  output kwl_pkg::lex_item_t head_item,
  input  logic               pop
);
  import kwl_pkg::*;

  lex_item_t         slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_pop;

  assign full       = (count == QCNT_W'(QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head_item  = slots[rd_ptr];
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop) rd_ptr <= rd_ptr + 1'b1;
      if (push && !do_pop) count <= count + 1'b1;
      else if (do_pop && !push) count <= count - 1'b1;
    end
  end

endmodule

// File: src/kwl_back.sv
module kwl_back #(
  parameter int LINE_BITS = kwl_pkg::LINE_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               head_valid,
  input  kwl_pkg::lex_item_t head_item,
  output logic               pop,
  kwl_tok_if.source          tokens
);
  import kwl_pkg::*;

  typedef struct packed {
    logic        vld;
    token_kind_t kind;
    logic [7:0]  chr;
  } res_t;

  typedef struct packed {
    res_t      res;
    lex_mode_t mode;
    logic      word_start;
  } idle_t;

  typedef struct packed {
    res_t      res;
    lex_mode_t mode;
  } close_t;

  function automatic res_t mk(token_kind_t k, logic [7:0] c);
    res_t r;
    r.vld  = 1'b1;
    r.kind = k;
    r.chr  = c;
    return r;
  endfunction

  function automatic token_kind_t word_kind(logic [39:0] p, logic [2:0] n);
    token_kind_t k;
    if (n == 3'd6 && p == KW_DEFIN) k = TK_DEFINE;
    else if (n == 3'd4 && p == KW_CALL) k = TK_CALL;
    else if (n == 3'd5 && p == KW_START) k = TK_START;
    else if (n == 3'd3 && p == KW_END) k = TK_END;
    else k = TK_IDENT;
    return k;
  endfunction

  function automatic logic [39:0] append_prefix(logic [39:0] p, logic [2:0] n,
                                                logic [7:0] c);
    logic [39:0] q;
    q = p;
    if (n < 3'd5) begin
      for (int k = 0; k < 5; k++) begin
        if (n == 3'(k)) q[8*k +: 8] = c;
      end
    end else if (n == 3'd5 && p == KW_DEFIN && c != CH_E) begin
      q = '0;
    end
    return q;
  endfunction

  function automatic idle_t idle_char(char_cls_t cls, logic [7:0] c);
    idle_t r;
    r            = '0;
    r.mode       = M_IDLE;
    unique case (cls)
      CLS_SPACE:   r.res = '0;
      CLS_LPAREN:  r.res = mk(TK_LPAREN, 8'd0);
      CLS_RPAREN:  r.res = mk(TK_RPAREN, 8'd0);
      CLS_PLUS:    r.res = mk(TK_PLUS, 8'd0);
      CLS_MINUS:   r.res = mk(TK_MINUS, 8'd0);
      CLS_STAR:    r.res = mk(TK_STAR, 8'd0);
      CLS_PERCENT: r.res = mk(TK_PERCENT, 8'd0);
      CLS_COMMA:   r.res = mk(TK_COMMA, 8'd0);
      CLS_SLASH:   r.mode = M_SLASH;
      CLS_QUOTE:   r.mode = M_STRING;
      CLS_DIGIT: begin
        r.mode = M_NUMBER;
        r.res  = mk(TK_TEXTBYTE, c);
      end
      CLS_ALPHA: begin
        r.mode       = M_IDENT;
        r.word_start = 1'b1;
        r.res        = mk(TK_TEXTBYTE, c);
      end
      default: begin
        r.mode = M_HALT;
        r.res  = mk(TK_BADCHAR, c);
      end
    endcase
    return r;
  endfunction

  function automatic close_t close_open(lex_mode_t m, logic [39:0] p, logic [2:0] n);
    close_t r;
    r      = '0;
    r.mode = M_IDLE;
    unique case (m)
      M_IDENT:  r.res = mk(word_kind(p, n), 8'd0);
      M_NUMBER: r.res = mk(TK_NUMBER, 8'd0);
      M_SLASH:  r.res = mk(TK_SLASH, 8'd0);
      M_STRING: begin
        r.res  = mk(TK_UNTERM, 8'd0);
        r.mode = M_HALT;
      end
      M_HALT:   r.mode = M_HALT;
      default:  r.res = '0;
    endcase
    return r;
  endfunction

  // lexer state
  lex_mode_t            mode, mode_next;
  logic [39:0]          word_prefix, word_prefix_next;
  logic [2:0]           word_length, word_length_next;
  logic [LINE_BITS-1:0] line_counter, line_counter_next;
  logic                 phase, phase_next;

  // output register
  logic                  out_valid;
  token_kind_t           out_kind;
  logic [7:0]            out_chr;
  logic [LINE_OUT_W-1:0] out_line;
  logic                  out_last;

  res_t                  r0, r1;
  idle_t                 ic;
  close_t                cl;
  logic                  commit, load, load_last, slot_free;
  res_t                  load_res;
  logic [31:0]           line_wide;
  logic [LINE_OUT_W-1:0] line_cap;
  logic [7:0]            c;
  logic                  is_word;
  logic [2:0]            len_inc;

  assign c         = head_item.char_code;
  assign is_word   = (head_item.cls == CLS_ALPHA) || (head_item.cls == CLS_DIGIT);
  assign len_inc   = (word_length == 3'd7) ? word_length : word_length + 3'd1;
  assign line_wide = 32'(line_counter);
  assign line_cap  = (line_wide > 32'(2**LINE_OUT_W - 1)) ? '1 : line_wide[LINE_OUT_W-1:0];
  assign slot_free = !out_valid || tokens.ready;

  // results and next state of the head word, from the current state alone
  always_comb begin
    r0                = '0;
    r1                = '0;
    mode_next         = mode;
    word_prefix_next  = word_prefix;
    word_length_next  = word_length;
    line_counter_next = line_counter;
    ic                = idle_char(head_item.cls, c);
    cl                = close_open(mode, word_prefix, word_length);
    unique case (head_item.opcode)
      OP_CHAR: begin
        unique case (mode)
          M_HALT: r0 = '0;
          M_STRING: begin
            if (head_item.cls == CLS_QUOTE) begin
              r0        = mk(TK_STRING, 8'd0);
              mode_next = M_IDLE;
            end else begin
              r0 = mk(TK_TEXTBYTE, c);
            end
          end
          M_IDENT: begin
            if (is_word) begin
              word_prefix_next = append_prefix(word_prefix, word_length, c);
              word_length_next = len_inc;
              r0               = mk(TK_TEXTBYTE, c);
            end else begin
              r0        = mk(word_kind(word_prefix, word_length), 8'd0);
              r1        = ic.res;
              mode_next = ic.mode;
            end
          end
          M_NUMBER: begin
            if (head_item.cls == CLS_DIGIT) begin
              r0 = mk(TK_TEXTBYTE, c);
            end else begin
              r0        = mk(TK_NUMBER, 8'd0);
              r1        = ic.res;
              mode_next = ic.mode;
            end
          end
          M_SLASH: begin
            if (head_item.cls == CLS_SLASH) begin
              r0        = mk(TK_SLASHSLASH, 8'd0);
              mode_next = M_IDLE;
            end else begin
              r0        = mk(TK_SLASH, 8'd0);
              r1        = ic.res;
              mode_next = ic.mode;
            end
          end
          default: begin
            r0        = ic.res;
            mode_next = ic.mode;
          end
        endcase
        // a new identifier starts a fresh prefix that holds its first character
        if (mode_next == M_IDENT && mode != M_IDENT && ic.word_start) begin
          word_prefix_next = {32'd0, c};
          word_length_next = 3'd1;
        end
      end
      OP_EOL: begin
        r0        = cl.res;
        mode_next = cl.mode;
        if (line_counter != '1) line_counter_next = line_counter + 1'b1;
      end
      OP_EOS: begin
        if (cl.res.vld) begin
          r0 = cl.res;
          r1 = mk(TK_EOF, 8'd0);
        end else begin
          r0 = mk(TK_EOF, 8'd0);
        end
        mode_next         = M_IDLE;
        word_prefix_next  = '0;
        word_length_next  = '0;
        line_counter_next = LINE_BITS'(1);
      end
      default: r0 = '0;
    endcase
  end

  // sequencing: one result per cycle into the output register while that register is free
  always_comb begin
    pop        = 1'b0;
    commit     = 1'b0;
    load       = 1'b0;
    load_res   = phase ? r1 : r0;
    load_last  = phase || !r1.vld;
    phase_next = phase;
    if (head_valid) begin
      if (!r0.vld) begin
        pop    = 1'b1;
        commit = 1'b1;
      end else if (slot_free) begin
        load = 1'b1;
        if (load_last) begin
          pop        = 1'b1;
          commit     = 1'b1;
          phase_next = 1'b0;
        end else begin
          phase_next = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= M_IDLE;
      word_prefix  <= '0;
      word_length  <= '0;
      line_counter <= LINE_BITS'(1);
      phase        <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      phase <= phase_next;
      if (commit) begin
        mode         <= mode_next;
        word_prefix  <= word_prefix_next;
        word_length  <= word_length_next;
        line_counter <= line_counter_next;
      end
      if (load) out_valid <= 1'b1;
      else if (tokens.ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_kind <= load_res.kind;
      out_chr  <= load_res.chr;
      out_line <= line_cap;
      out_last <= load_last;
    end
  end

  assign tokens.valid       = out_valid;
  assign tokens.token_kind  = out_kind;
  assign tokens.text_byte   = out_chr;
  assign tokens.line_number = out_line;
  assign tokens.last        = out_last;

endmodule

// File: src/keyword_token_lexer_unit.sv
// keyword token lexer: takes one word per cycle on chars (a character, an end of line
// or an end of source) while the queue has room, and gives tokens on tokens, each
// tagged with the one-based line number, saturating at 65535. identifier, number and
// string characters leave at once as text-byte tokens; the identifier kind (define,
// call, start, end or plain identifier) follows when the word closes. a slash is held
// back one word so that a second slash makes a double slash. an unexpected character
// or an open string at a line end gives an error token, after which input is
// swallowed until end of source, which always closes with EOF and returns the lexer
// to its reset state. rate: one input word per cycle while tokens are taken; a word
// that closes one token and gives another, or an end of source that closes a token,
// yields two tokens and holds the back end until both are loaded, since the single
// output register takes one token a cycle. a four-entry queue between the classifying
// front end and the lexer keeps input flowing through such stalls. with the queue empty
// the first token passes through a queue slot and the output register before it is offered.
module keyword_token_lexer_unit #(
  parameter int LINE_BITS = kwl_pkg::LINE_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  kwl_char_if.sink  chars,
  kwl_tok_if.source tokens
);
  import kwl_pkg::*;

  // front end to queue
  logic      push;
  lex_item_t push_item;
  logic      full;

  // queue to lexer
  logic      head_valid;
  lex_item_t head_item;
  logic      pop;

  // classify each word as it is accepted
  kwl_front u_front (
    .chars     (chars),
    .full      (full),
    .push      (push),
    .push_item (push_item)
  );

  // short decoupling queue
  kwl_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_item  (push_item),
    .full       (full),
    .head_valid (head_valid),
    .head_item  (head_item),
    .pop        (pop)
  );

  // lexer state machine and output register
  kwl_back #(
    .LINE_BITS (LINE_BITS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_item  (head_item),
    .pop        (pop),
    .tokens     (tokens)
  );

endmodule
